/* rtl/fnpm_pkg.sv */
// Shared types and constants for the four-neighbour peak marker.
`timescale 1ns / 1ps

package fnpm_pkg;

    localparam int CFG_BITS = 11;
    localparam int ROW_BITS = 10;

    localparam logic [CFG_BITS-1:0] MAX_HEIGHT          = 11'd1024;
    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET   = 11'd1024;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET  = 11'd1024;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

endpackage

/* rtl/four_neighbour_peak_marker_core.sv */
// Four-neighbour strict peak marker: line store, neighbour compare and output register.
`timescale 1ns / 1ps

// Usage
//   s_* stream: one transfer per pixel in row order; s_tuser selects a new pixel
//   (CMD_PIXEL) or a drain step (CMD_DRAIN). s_tdata carries the pixel value.
//   m_* stream: one transfer per emitted pixel with its peak flag in m_tuser and
//   m_tlast on the final pixel of the frame.
//   cfg_* channel: write frame_width (index 0) or frame_height (index 1) while
//   the block is idle; cfg_ready is always high.
// Timing
//   Pixel (r,c) is loaded into the output register on the transfer of pixel
//   (r+1,c); the last row is loaded on each drain transfer.
//   One transfer per cycle is sustained while m_tready holds: a single line memory
//   with two read ports and one write port serves each column.
// Reset
//   rst_n clears position, drain state and output valid; frame width and
//   height return to 1024. The line memory is not cleared and needs no sweep.
// Stall
//   When m_tready is low with a result waiting, s_tready drops until the
//   result is taken; nothing is lost or repeated.
module four_neighbour_peak_marker_core
    import fnpm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // [PIXEL_BITS-1:0] pixel
    input  logic [0:0]                              s_tuser,  // [0] command
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // [PIXEL_BITS-1:0] pixel_out
    output logic [0:0]                              m_tuser,  // [0] is_peak
    output logic                                    m_tlast,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [0:0]                              cfg_index,
    input  logic [CFG_BITS-1:0]                     cfg_data
);

    localparam int DW = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int MW = 2 * PIXEL_BITS;
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam logic [EW-1:0] MAX_W_E  = EW'(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_COL = AW'(MAX_WIDTH - 1);

    logic [CFG_BITS-1:0]   frame_width_reg;
    logic [CFG_BITS-1:0]   frame_height_reg;
    logic [AW-1:0]         col_reg;
    logic [AW-1:0]         col_next;
    logic [ROW_BITS-1:0]   row_reg;
    logic [ROW_BITS-1:0]   row_next;
    logic                  drain_reg;
    logic                  drain_next;

    logic [MW-1:0]         line_mem [MAX_WIDTH];
    logic [MW-1:0]         word_cur_reg;
    logic [MW-1:0]         word_nxt_reg;
    logic [PIXEL_BITS-1:0] left_reg;

    logic                  out_valid_reg;
    logic [PIXEL_BITS-1:0] out_pixel_reg;
    logic                  out_peak_reg;
    logic                  out_last_reg;

    logic                  acc;
    cmd_t                  cmd;
    logic [PIXEL_BITS-1:0] pix;
    logic [PIXEL_BITS-1:0] center;
    logic [PIXEL_BITS-1:0] up;
    logic [PIXEL_BITS-1:0] right;
    logic [EW-1:0]         fw_e;
    logic [EW-1:0]         eff_w;
    logic [CFG_BITS-1:0]   eff_h;
    logic [EW-1:0]         col_inc;
    logic [CFG_BITS-1:0]   row_inc;
    logic                  row_end;
    logic                  last_row;
    logic                  peak_hit;
    logic                  wr_en;
    logic [MW-1:0]         wr_word;
    logic [AW-1:0]         rd_a;
    logic [AW-1:0]         rd_b;
    logic                  emit;
    logic                  res_peak;
    logic                  res_last;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign acc       = s_tvalid && s_tready;
    assign cmd       = cmd_t'(s_tuser[0]);
    assign pix       = s_tdata[PIXEL_BITS-1:0];

    assign center = word_cur_reg[PIXEL_BITS-1:0];
    assign up     = word_cur_reg[MW-1:PIXEL_BITS];
    assign right  = word_nxt_reg[PIXEL_BITS-1:0];

    always_comb
    begin
        fw_e = EW'(frame_width_reg);
        if (fw_e == '0)
        begin
            eff_w = EW'(1);
        end
        else if (fw_e > MAX_W_E)
        begin
            eff_w = MAX_W_E;
        end
        else
        begin
            eff_w = fw_e;
        end

        if (frame_height_reg == '0)
        begin
            eff_h = CFG_BITS'(1);
        end
        else if (frame_height_reg > MAX_HEIGHT)
        begin
            eff_h = MAX_HEIGHT;
        end
        else
        begin
            eff_h = frame_height_reg;
        end
    end

    assign col_inc  = EW'(col_reg) + EW'(1);
    assign row_inc  = CFG_BITS'(row_reg) + CFG_BITS'(1);
    assign row_end  = col_inc >= eff_w;
    assign last_row = row_inc >= eff_h;

    assign peak_hit = (row_reg >= ROW_BITS'(2)) && (col_reg != '0) && !row_end
                      && (center > up) && (center > pix)
                      && (center > left_reg) && (center > right);

    assign wr_word = {center, pix};

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        wr_en      = 1'b0;
        emit       = 1'b0;
        res_peak   = 1'b0;
        res_last   = 1'b0;
        if (acc)
        begin
            case (cmd)
                CMD_DRAIN:
                begin
                    if (drain_reg)
                    begin
                        emit     = 1'b1;
                        res_last = row_end;
                        if (row_end)
                        begin
                            col_next   = '0;
                            drain_next = 1'b0;
                        end
                        else
                        begin
                            col_next = col_reg + AW'(1);
                        end
                    end
                end
                CMD_PIXEL:
                begin
                    if (!drain_reg)
                    begin
                        wr_en    = 1'b1;
                        emit     = (row_reg != '0);
                        res_peak = peak_hit;
                        if (row_end)
                        begin
                            col_next = '0;
                            if (last_row)
                            begin
                                row_next   = '0;
                                drain_next = 1'b1;
                            end
                            else
                            begin
                                row_next = row_reg + ROW_BITS'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + AW'(1);
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    assign rd_a = col_next;
    assign rd_b = (col_next == LAST_COL) ? '0 : col_next + AW'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[col_reg] <= wr_word;
            left_reg          <= center;
        end
        if (acc)
        begin
            if (wr_en && (rd_a == col_reg))
            begin
                word_cur_reg <= wr_word;
            end
            else
            begin
                word_cur_reg <= line_mem[rd_a];
            end
            if (wr_en && (rd_b == col_reg))
            begin
                word_nxt_reg <= wr_word;
            end
            else
            begin
                word_nxt_reg <= line_mem[rd_b];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index[0]))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
            if (acc)
            begin
                out_valid_reg <= emit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && emit)
        begin
            out_pixel_reg <= center;
            out_peak_reg  <= res_peak;
            out_last_reg  <= res_last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = DW'(out_pixel_reg);
    assign m_tuser[0] = out_peak_reg;
    assign m_tlast    = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> (row_reg == '0))
        else $error("row not at zero while draining");

    assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= LAST_COL)
        else $error("column beyond line store");

    assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (cmd == CMD_DRAIN) && !drain_reg) |=> !m_tvalid)
        else $error("drain outside drain phase produced a transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (cmd == CMD_PIXEL) && !drain_reg && (row_reg != '0)) |=> m_tvalid)
        else $error("pixel below first row produced no transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> !m_tlast)
        else $error("peak flagged on last pixel of frame");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the four-neighbour peak marker core.
`timescale 1ns / 1ps

module testbench
    import fnpm_pkg::*;
();

    localparam int MAX_COLS = 1024;

    typedef struct packed {
        logic [7:0] value;
        logic       peak;
        logic       last;
    } marked_pixel_t;

    class peak_marker_board;
        logic [CFG_BITS-1:0] width_reg;
        logic [CFG_BITS-1:0] height_reg;
        logic [7:0]          upper_row [MAX_COLS];
        logic [7:0]          middle_row [MAX_COLS];
        int unsigned         column;
        int unsigned         row;
        bit                  draining;
        marked_pixel_t       expected_marks [$];
        int                  failures;
        int                  reported;

        function new();
            width_reg  = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            foreach (upper_row[i])
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            column   = 0;
            row      = 0;
            draining = 1'b0;
            failures = 0;
            reported = 0;
        endfunction

        function int unsigned active_width();
            int unsigned w;
            w = 32'(width_reg);
            if (w == 0)
                w = 1;
            if (w > MAX_COLS)
                w = MAX_COLS;
            return w;
        endfunction

        function int unsigned active_height();
            int unsigned h;
            h = 32'(height_reg);
            if (h == 0)
                h = 1;
            if (h > MAX_HEIGHT)
                h = MAX_HEIGHT;
            return h;
        endfunction

        function void write_register(cfg_reg_t index, logic [CFG_BITS-1:0] data);
            if (index == REG_FRAME_WIDTH)
                width_reg = data;
            else
                height_reg = data;
        endfunction

        function int outstanding();
            return expected_marks.size();
        endfunction

        function void note_pixel_transfer(cmd_t cmd, logic [7:0] pix);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            logic [7:0]  center;
            bit          peak;
            w = active_width();
            h = active_height();
            c = column;
            if (c >= MAX_COLS)
                c = 0;
            if (cmd == CMD_DRAIN)
            begin
                if (!draining)
                    return;
                expected_marks.push_back('{middle_row[c], 1'b0, c + 1 >= w});
                if (c + 1 >= w)
                begin
                    column   = 0;
                    draining = 1'b0;
                end
                else
                    column = c + 1;
                return;
            end
            if (draining)
                return;
            center = middle_row[c];
            if (row >= 1)
            begin
                peak = 1'b0;
                if (row >= 2 && c >= 1 && c + 1 < w)
                    peak = center > upper_row[c] && center > pix &&
                           center > upper_row[c - 1] && center > middle_row[c + 1];
                expected_marks.push_back('{center, peak, 1'b0});
            end
            upper_row[c]  = center;
            middle_row[c] = pix;
            if (c + 1 >= w)
            begin
                column = 0;
                if (row + 1 >= h)
                begin
                    row      = 0;
                    draining = 1'b1;
                end
                else
                    row = row + 1;
            end
            else
                column = c + 1;
        endfunction

        function void report_mismatch(string what);
            failures++;
            if (reported < 10)
            begin
                reported++;
                $display("%0t ns: %s", $realtime, what);
            end
        endfunction

        function void check_marked_pixel(logic [7:0] value, logic peak, logic last);
            marked_pixel_t want;
            if (expected_marks.size() == 0)
            begin
                report_mismatch($sformatf("unexpected pixel %0d peak %0b last %0b",
                                          value, peak, last));
                return;
            end
            want = expected_marks.pop_front();
            if (want.value !== value || want.peak !== peak || want.last !== last)
                report_mismatch($sformatf(
                    "mismatch: expected pixel %0d peak %0b last %0b, got %0d %0b %0b",
                    want.value, want.peak, want.last, value, peak, last));
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;   // [7:0] pixel
    logic [0:0]          s_tuser   = '0;   // [0] command
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;          // [7:0] pixel_out
    logic [0:0]          m_tuser;          // [0] is_peak
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [0:0]          cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data  = '0;

    peak_marker_board board = new();
    bit               steady_source = 1'b0;
    int               ready_hold    = 0;
    int               stream_items  = 0;
    int               frame_items;

    four_neighbour_peak_marker_core #(
        .MAX_WIDTH  (MAX_COLS),
        .PIXEL_BITS (8)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            board.write_register(cfg_reg_t'(cfg_index), cfg_data);
        if (rst_n && s_tvalid && s_tready)
            board.note_pixel_transfer(cmd_t'(s_tuser), s_tdata);
        if (rst_n && m_tvalid && m_tready)
            board.check_marked_pixel(m_tdata, m_tuser[0], m_tlast);
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Randomly stall the result side, with long stretches of steady ready.
    always @(negedge clk)
    begin
        int roll;
        if (ready_hold > 0)
            ready_hold--;
        else
        begin
            roll = $urandom_range(99);
            if (roll < 15)
            begin
                m_tready   <= 1'b1;
                ready_hold = $urandom_range(30, 120);
            end
            else if (roll < 55)
            begin
                m_tready   <= 1'b1;
                ready_hold = $urandom_range(0, 3);
            end
            else
            begin
                m_tready   <= 1'b0;
                ready_hold = pick_gap();
            end
        end
    end

    function automatic int sender_gap();
        if (steady_source)
            return 0;
        return pick_gap();
    endfunction

    function automatic logic [7:0] pick_pixel(int style);
        case (style)
            0:       return 8'($urandom_range(255));
            1:       return 8'($urandom_range(3));
            2:       return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(250, 255));
        endcase
    endfunction

    task automatic send_item(cmd_t cmd, logic [7:0] pix, int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_pixels(int count, int style);
        repeat (count) send_item(CMD_PIXEL, pick_pixel(style), sender_gap());
    endtask

    task automatic send_drains(int count);
        repeat (count) send_item(CMD_DRAIN, 8'($urandom_range(255)), sender_gap());
    endtask

    task automatic send_grid3(logic [71:0] grid);
        for (int i = 8; i >= 0; i--)
            send_item(CMD_PIXEL, grid[i*8 +: 8], sender_gap());
    endtask

    // Hold the source until every result is out and the pipeline has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(cfg_reg_t index, logic [CFG_BITS-1:0] data, bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        if (!hold)
            cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
        wait_idle();
        cfg_write(REG_FRAME_WIDTH, w, 1'b1);
        cfg_write(REG_FRAME_HEIGHT, h, 1'b0);
    endtask

    task automatic random_frame(bit reconfigure, output int sent);
        int          roll;
        int          style;
        bit          noisy;
        int unsigned w;
        int unsigned h;
        logic [CFG_BITS-1:0] w_raw;
        logic [CFG_BITS-1:0] h_raw;
        if (reconfigure)
        begin
            roll = $urandom_range(99);
            if (roll < 80)
                w_raw = CFG_BITS'($urandom_range(1, 8));
            else if (roll < 92)
                w_raw = CFG_BITS'($urandom_range(9, 40));
            else if (roll < 97)
                w_raw = CFG_BITS'($urandom_range(41, 64));
            else
                w_raw = '0;
            roll = $urandom_range(99);
            if (roll < 85)
                h_raw = CFG_BITS'($urandom_range(1, 8));
            else if (roll < 97)
                h_raw = CFG_BITS'($urandom_range(9, 16));
            else
                h_raw = '0;
            if (w_raw > 16 && h_raw > 4)
                h_raw = CFG_BITS'($urandom_range(1, 4));
            configure(w_raw, h_raw);
        end
        w             = board.active_width();
        h             = board.active_height();
        style         = $urandom_range(3);
        noisy         = $urandom_range(9) < 3;
        steady_source = $urandom_range(3) == 0;
        repeat (w * h)
        begin
            if (noisy && $urandom_range(19) == 0)
                send_item(CMD_DRAIN, 8'($urandom_range(255)), sender_gap());
            send_item(CMD_PIXEL, pick_pixel(style), sender_gap());
        end
        repeat (w)
        begin
            if (noisy && $urandom_range(19) == 0)
                send_item(CMD_PIXEL, 8'($urandom_range(255)), sender_gap());
            send_item(CMD_DRAIN, 8'($urandom_range(255)), sender_gap());
        end
        if (noisy && $urandom_range(1) == 1)
            send_item(CMD_DRAIN, 8'($urandom_range(255)), sender_gap());
        sent = w * h + w;
    endtask

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset geometry, then cut width and height while the column sits past the new edge.
        send_pixels(9, 0);
        configure(11'd4, 11'd2);
        send_pixels(5, 0);
        send_drains(4);

        // Zero sizes act as one; stray drains and pixels are dropped.
        configure(11'd0, 11'd0);
        send_item(CMD_DRAIN, 8'hFF, sender_gap());
        send_item(CMD_PIXEL, 8'hFF, sender_gap());
        send_item(CMD_PIXEL, 8'h00, sender_gap());
        send_item(CMD_DRAIN, 8'h00, sender_gap());
        send_item(CMD_DRAIN, 8'hFF, sender_gap());

        // Oversized width holds the row open; single row drains without peaks.
        configure(11'd2047, 11'd1);
        send_pixels(12, 2);
        wait_idle();
        cfg_write(REG_FRAME_WIDTH, 11'd6, 1'b0);
        send_pixels(1, 2);
        send_drains(6);

        // Single column with oversized height, then cut the height below the row.
        configure(11'd1, 11'd2047);
        send_pixels(20, 0);
        wait_idle();
        cfg_write(REG_FRAME_HEIGHT, 11'd5, 1'b0);
        send_pixels(1, 0);
        send_drains(1);

        // Clear peak, peak at full scale, and ties that must not flag.
        configure(11'd3, 11'd3);
        send_grid3({8'd0, 8'd10, 8'd0, 8'd10, 8'd200, 8'd10, 8'd0, 8'd10, 8'd0});
        send_drains(3);
        send_grid3({8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd254, 8'd254, 8'd254,
                    8'd254});
        send_drains(3);
        send_grid3({8'd0, 8'd9, 8'd0, 8'd9, 8'd9, 8'd8, 8'd0, 8'd8, 8'd0});
        send_drains(3);
        send_grid3({8'd1, 8'd1, 8'd1, 8'd1, 8'd5, 8'd5, 8'd1, 8'd1, 8'd1});
        send_drains(3);
        send_grid3({8'd1, 8'd1, 8'd1, 8'd1, 8'd5, 8'd1, 8'd1, 8'd5, 8'd1});
        send_drains(3);

        // Shrink the width while the column sits beyond the new edge.
        configure(11'd5, 11'd4);
        send_pixels(9, 1);
        wait_idle();
        cfg_write(REG_FRAME_WIDTH, 11'd3, 1'b0);
        send_pixels(7, 1);
        send_drains(3);

        while (stream_items < 1000)
        begin
            random_frame(stream_items == 0 || $urandom_range(9) < 6, frame_items);
            stream_items += frame_items;
        end

        s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
